// ===== design/free_list_block_allocator_assert.svh =====
// Assertion macros for the free list block allocator checker.
`ifndef FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define FLA_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define FLA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

// ===== design/fla_pkg.sv =====
// Shared types and constants of the free list block allocator.
`default_nettype none

package fla_pkg;

	localparam int BLOCKS_DEF      = 1024;
	localparam int MAX_REQUEST_DEF = 64;

	localparam int SLAB_W   = 16;
	localparam int BLK_W    = 10;
	localparam int REQ_W    = 7;
	localparam int BCOUNT_W = 11;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [BCOUNT_W-1:0] BCOUNT_RST = 11'd1024;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_SLAB_NUMBER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_GRANT       = 2'd0,
		ST_EXHAUSTED   = 2'd1,
		ST_FREE_OK     = 2'd2,
		ST_FREE_REJECT = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ===== design/fla_if.sv =====
// Command and response channel interfaces of the free list block allocator.
`default_nettype none

interface fla_cmd_if;
	import fla_pkg::*;

	logic              valid;
	logic              ready;
	logic              command;
	logic [REQ_W-1:0]  request_count;
	logic [SLAB_W-1:0] owner_slab;
	logic [BLK_W-1:0]  freed_block;

	modport source (output valid, command, request_count, owner_slab, freed_block,
		input ready);
	modport sink (input valid, command, request_count, owner_slab, freed_block,
		output ready);
endinterface

interface fla_rsp_if;
	import fla_pkg::*;

	logic              valid;
	logic              ready;
	status_t           status;
	logic [SLAB_W-1:0] granted_slab;
	logic [BLK_W-1:0]  granted_block;
	logic              last;

	modport source (output valid, status, granted_slab, granted_block, last,
		input ready);
	modport sink (input valid, status, granted_slab, granted_block, last,
		output ready);
endinterface

`default_nettype wire

// ===== design/free_list_block_allocator.sv =====
// Free list block allocator for one slab: link memory free list plus bump pointer.
// Free: result registered at the transfer edge, valid the next cycle, no gap if rsp is ready.
// Allocate: the command enters the run state, then one grant per cycle as the output drains;
// the next-link read-ahead from the registered-read link memory sets that one-per-cycle pace.
// Reset clears head, bump pointer and handshake state, resets config; link memory is kept.
`default_nettype none

module free_list_block_allocator #(
	parameter int BLOCKS      = fla_pkg::BLOCKS_DEF,
	parameter int MAX_REQUEST = fla_pkg::MAX_REQUEST_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	fla_cmd_if.sink                           cmd,
	fla_rsp_if.source                         rsp,
	input  wire logic                         cfg_wr_en,
	input  wire logic [fla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fla_pkg::CFG_W-1:0]    cfg_data
);
	import fla_pkg::*;

	localparam int IDX_W  = $clog2(BLOCKS);
	localparam int POS_W  = $clog2(BLOCKS + 1);
	localparam int CNT_W  = $clog2(MAX_REQUEST + 1);
	localparam int LINK_W = IDX_W + 1;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
	} link_t;

	typedef enum logic {S_IDLE, S_RUN} state_t;

	state_t              state_q;
	link_t               head_q;
	link_t               nxt_q;
	logic                nxt_ram_q;
	logic [POS_W-1:0]    bump_q;
	logic [CNT_W-1:0]    remain_q;
	logic [SLAB_W-1:0]   slab_q;
	logic [BCOUNT_W-1:0] bcount_q;

	logic                out_valid_q;
	status_t             status_q;
	logic [SLAB_W-1:0]   gslab_q;
	logic [BLK_W-1:0]    gblock_q;
	logic                last_q;

	logic              slot_free;
	logic              cmd_fire;
	logic              is_free;
	logic              free_ok;
	logic [IDX_W-1:0]  freed_idx;
	logic [CNT_W-1:0]  req_cap;
	logic [LINK_W-1:0] ram_rdata;
	link_t             nxt_cur;
	logic              step;
	logic              have_list;
	logic              have_bump;
	logic              pop;
	logic [IDX_W-1:0]  blk;
	logic              ram_we;
	logic              ram_re;

	assign slot_free = !out_valid_q || rsp.ready;
	assign cmd.ready = (state_q == S_IDLE) && slot_free;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign is_free   = cmd.command == CMD_FREE;
	assign free_ok   = (cmd.owner_slab == slab_q) && (32'(cmd.freed_block) < BLOCKS);
	assign freed_idx = IDX_W'(cmd.freed_block);
	assign req_cap   = (32'(cmd.request_count) > MAX_REQUEST) ? CNT_W'(MAX_REQUEST)
		: CNT_W'(cmd.request_count);

	assign nxt_cur   = nxt_ram_q ? link_t'(ram_rdata) : nxt_q;
	assign step      = (state_q == S_RUN) && slot_free;
	assign have_list = head_q.valid;
	assign have_bump = (32'(bump_q) < 32'(bcount_q)) && (32'(bump_q) < BLOCKS);
	assign pop       = step && have_list;
	assign blk       = have_list ? head_q.idx : IDX_W'(bump_q);

	assign ram_we = cmd_fire && is_free && free_ok;
	assign ram_re = pop && nxt_cur.valid;

	fla_ram #(
		.WIDTH (LINK_W),
		.DEPTH (BLOCKS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (freed_idx),
		.wdata (head_q),
		.re    (ram_re),
		.raddr (nxt_cur.idx),
		.rdata (ram_rdata)
	);

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.granted_slab  = gslab_q;
	assign rsp.granted_block = gblock_q;
	assign rsp.last          = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			nxt_q       <= '0;
			nxt_ram_q   <= 1'b0;
			bump_q      <= '0;
			remain_q    <= '0;
			slab_q      <= '0;
			bcount_q    <= BCOUNT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_SLAB_NUMBER: slab_q   <= cfg_data;
					CFG_BLOCK_COUNT: bcount_q <= cfg_data[BCOUNT_W-1:0];
					default: ;
				endcase
			end

			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			// park read-ahead data before the RAM output moves on
			if (nxt_ram_q && !pop) begin
				nxt_q     <= link_t'(ram_rdata);
				nxt_ram_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						if (is_free) begin
							out_valid_q <= 1'b1;
							gslab_q     <= '0;
							gblock_q    <= '0;
							last_q      <= 1'b1;
							if (free_ok) begin
								status_q  <= ST_FREE_OK;
								head_q    <= '{valid: 1'b1, idx: freed_idx};
								nxt_q     <= head_q;
								nxt_ram_q <= 1'b0;
							end else begin
								status_q <= ST_FREE_REJECT;
							end
						end else if (req_cap != '0) begin
							remain_q <= req_cap;
							state_q  <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (step) begin
						out_valid_q <= 1'b1;
						if (have_list || have_bump) begin
							status_q <= ST_GRANT;
							gslab_q  <= slab_q;
							gblock_q <= BLK_W'(blk);
							last_q   <= remain_q == CNT_W'(1);
							remain_q <= remain_q - CNT_W'(1);
							if (remain_q == CNT_W'(1)) begin
								state_q <= S_IDLE;
							end
							if (have_list) begin
								head_q    <= nxt_cur;
								nxt_ram_q <= nxt_cur.valid;
							end else begin
								bump_q <= bump_q + POS_W'(1);
							end
						end else begin
							status_q <= ST_EXHAUSTED;
							gslab_q  <= '0;
							gblock_q <= '0;
							last_q   <= 1'b1;
							state_q  <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/fla_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module fla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/fla_checker.sv =====
// Port-level assertions for the free list block allocator, bound to the top level.
`default_nettype none

`include "free_list_block_allocator_assert.svh"

module fla_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       in_command,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire fla_pkg::status_t           out_status,
	input wire logic [fla_pkg::SLAB_W-1:0] out_granted_slab,
	input wire logic [fla_pkg::BLK_W-1:0]  out_granted_block,
	input wire logic                       out_last
);
	import fla_pkg::*;

	`FLA_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_granted_slab) && $stable(out_granted_block) && $stable(out_last), "response changed while stalled")

	`FLA_ASSERT_NEXT(a_free_result, in_valid && in_ready && in_command == CMD_FREE, out_valid && out_last && (out_status == ST_FREE_OK || out_status == ST_FREE_REJECT), "free transfer without its result")

	`FLA_ASSERT(a_nongrant_last, out_valid && out_status != ST_GRANT |-> out_last, "non-grant result not marked last")

	`FLA_ASSERT(a_nongrant_zero, out_valid && out_status != ST_GRANT |-> out_granted_slab == '0 && out_granted_block == '0, "non-grant result carries a block")

endmodule

bind free_list_block_allocator fla_checker u_fla_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (cmd.valid),
	.in_ready          (cmd.ready),
	.in_command        (cmd.command),
	.out_valid         (rsp.valid),
	.out_ready         (rsp.ready),
	.out_status        (rsp.status),
	.out_granted_slab  (rsp.granted_slab),
	.out_granted_block (rsp.granted_block),
	.out_last          (rsp.last)
);

`default_nettype wire

// ===== tb/fla_grant_checker.sv =====
// Checker for the free list block allocator: tracks list, bump pointer and registers, compares results.
module fla_grant_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	fla_cmd_if                            cmd,
	fla_rsp_if                            rsp,
	input  logic                          cfg_wr_en,
	input  logic [fla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fla_pkg::CFG_W-1:0]     cfg_data,
	output int                            errors,
	output int                            pending,
	output int                            checked
);
	import fla_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t           status;
		logic [SLAB_W-1:0] slab;
		logic [BLK_W-1:0]  blk;
		logic              last;
	} outcome_t;

	logic [BLK_W-1:0]    link_idx [BLOCKS_DEF];
	logic                link_ok  [BLOCKS_DEF];
	logic                head_ok;
	logic [BLK_W-1:0]    head_idx;
	int                  bump;
	logic [SLAB_W-1:0]   slab_id;
	logic [BCOUNT_W-1:0] bump_limit_reg;
	outcome_t            due_results[$];
	outcome_t            want;

	task automatic add_outcome(input status_t s, input logic [SLAB_W-1:0] sl,
			input logic [BLK_W-1:0] b, input logic l);
		outcome_t o;
		o = '{s, sl, b, l};
		due_results.insert(due_results.size(), o);
	endtask

	task automatic apply_command(input logic c, input logic [REQ_W-1:0] req_in,
			input logic [SLAB_W-1:0] owner, input logic [BLK_W-1:0] blk);
		int req;
		int limit;
		logic [BLK_W-1:0] pick;
		if (c == CMD_FREE) begin
			if (owner != slab_id || int'(blk) >= BLOCKS_DEF) begin
				add_outcome(ST_FREE_REJECT, '0, '0, 1'b1);
			end else begin
				link_ok[blk]  = head_ok;
				link_idx[blk] = head_idx;
				head_ok       = 1'b1;
				head_idx      = blk;
				add_outcome(ST_FREE_OK, '0, '0, 1'b1);
			end
		end else begin
			req   = (int'(req_in) > MAX_REQUEST_DEF) ? MAX_REQUEST_DEF : int'(req_in);
			limit = (int'(bump_limit_reg) < BLOCKS_DEF) ? int'(bump_limit_reg) : BLOCKS_DEF;
			for (int i = 0; i < req; i++) begin
				if (head_ok) begin
					pick     = head_idx;
					head_ok  = link_ok[pick];
					head_idx = link_idx[pick];
				end else if (bump < limit) begin
					pick = BLK_W'(bump);
					bump++;
				end else begin
					add_outcome(ST_EXHAUSTED, '0, '0, 1'b1);
					break;
				end
				add_outcome(ST_GRANT, slab_id, pick, (i + 1 == req));
			end
		end
	endtask

	task automatic check_field(input string what, input logic [SLAB_W-1:0] exp_v,
			input logic [SLAB_W-1:0] got);
		if (got !== exp_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ok        = 1'b0;
			head_idx       = '0;
			bump           = 0;
			slab_id        = '0;
			bump_limit_reg = BCOUNT_RST;
			due_results.delete();
			errors         = 0;
			checked        = 0;
			pending       <= 0;
		end else begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				checked++;
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t: result with none due, expected nothing, got status %0d block %0d",
						$time, rsp.status, rsp.granted_block);
				end else begin
					want = due_results.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("granted_slab", want.slab, rsp.granted_slab);
					check_field("granted_block", want.blk, rsp.granted_block);
					check_field("last", want.last, rsp.last);
				end
			end
			if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
				apply_command(cmd.command, cmd.request_count, cmd.owner_slab, cmd.freed_block);
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_SLAB_NUMBER: begin
						slab_id = cfg_data[SLAB_W-1:0];
					end
					CFG_BLOCK_COUNT: begin
						bump_limit_reg = cfg_data[BCOUNT_W-1:0];
					end
					default: begin
					end
				endcase
			end
			pending <= due_results.size();
		end
	end

endmodule

// ===== tb/free_list_block_allocator_tb.sv =====
// Top-level testbench for the free list block allocator: stimulus, flow control and verdict.
module free_list_block_allocator_tb;
	import fla_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   errors;
	int                   pending;
	int                   checked;
	logic [SLAB_W-1:0]    slab_now;
	logic [BLK_W-1:0]     held_blocks[$];
	bit                   long_stall_req;
	bit                   tx_steady;
	bit                   rx_steady;
	int                   n_alloc;
	int                   n_free;
	int                   n_writes;

	fla_cmd_if cmd_ch ();
	fla_rsp_if rsp_ch ();

	free_list_block_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fla_grant_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// response side flow control, with one long hold-off on request
	initial begin : rsp_ready_gen
		int gap;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (200) @(posedge clk);
			end else begin
				if ($urandom_range(0, 15) == 0)
					rx_steady = !rx_steady;
				gap = rx_steady ? 0 : $urandom_range(0, 5);
				if (gap > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
		end
	end

	// blocks currently handed out, candidates for a legal free
	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1 && rsp_ch.status == ST_GRANT)
			held_blocks.insert(held_blocks.size(), rsp_ch.granted_block);
	end

	task automatic send_cmd(input logic c, input logic [REQ_W-1:0] cnt,
			input logic [SLAB_W-1:0] owner, input logic [BLK_W-1:0] blk);
		int gap;
		if ($urandom_range(0, 15) == 0)
			tx_steady = !tx_steady;
		gap = tx_steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.command       <= c;
		cmd_ch.request_count <= cnt;
		cmd_ch.owner_slab    <= owner;
		cmd_ch.freed_block   <= blk;
		cmd_ch.valid         <= 1'b1;
		do @(posedge clk); while (!(cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1));
		if (c == CMD_ALLOC)
			n_alloc++;
		else
			n_free++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_SLAB_NUMBER)
			slab_now = data[SLAB_W-1:0];
		n_writes++;
	endtask

	// zero-count allocates give no result, hence the trailing pause
	task automatic wait_drain();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_phase(input int items);
		int r;
		int s;
		int k;
		logic [REQ_W-1:0]  cnt;
		logic [SLAB_W-1:0] owner;
		logic [BLK_W-1:0]  blk;
		held_blocks.delete();
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45 || (r < 85 && held_blocks.size() == 0)) begin
				s = $urandom_range(0, 19);
				if (s == 0)
					cnt = '0;
				else if (s < 14)
					cnt = REQ_W'($urandom_range(1, 8));
				else if (s < 18)
					cnt = REQ_W'($urandom_range(9, 64));
				else
					cnt = REQ_W'($urandom_range(65, 127));
				send_cmd(CMD_ALLOC, cnt, SLAB_W'($urandom), BLK_W'($urandom));
			end else if (r < 85) begin
				k = $urandom_range(0, held_blocks.size() - 1);
				blk = held_blocks[k];
				held_blocks.delete(k);
				send_cmd(CMD_FREE, REQ_W'($urandom), slab_now, blk);
			end else begin
				owner = SLAB_W'($urandom);
				if (owner == slab_now)
					owner[0] = ~owner[0];
				send_cmd(CMD_FREE, REQ_W'($urandom), owner, BLK_W'($urandom_range(0, 1023)));
			end
		end
	endtask

	initial begin : stimulus
		logic [BLK_W-1:0] twice;
		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_index            = CFG_SLAB_NUMBER;
		cfg_data             = '0;
		cmd_ch.valid         = 1'b0;
		cmd_ch.command       = CMD_ALLOC;
		cmd_ch.request_count = '0;
		cmd_ch.owner_slab    = '0;
		cmd_ch.freed_block   = '0;
		slab_now             = '0;
		long_stall_req       = 1'b0;
		tx_steady            = 1'b0;
		rx_steady            = 1'b0;
		n_alloc              = 0;
		n_free               = 0;
		n_writes             = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// single-block slab: bump exhaustion, zero and oversized requests, recycling
		write_reg(CFG_SLAB_NUMBER, 16'h0000);
		write_reg(CFG_BLOCK_COUNT, 16'd1);
		send_cmd(CMD_ALLOC, 7'd1, '0, '0);
		send_cmd(CMD_ALLOC, 7'd1, '0, '0);
		send_cmd(CMD_ALLOC, 7'd0, '0, '0);
		send_cmd(CMD_FREE, '0, 16'h0000, 10'd0);
		send_cmd(CMD_FREE, '0, 16'hFFFF, 10'd0);
		send_cmd(CMD_ALLOC, 7'd127, '0, '0);
		send_cmd(CMD_FREE, '0, 16'h0000, 10'd0);
		send_cmd(CMD_ALLOC, 7'd2, '0, '0);
		wait_drain();

		write_reg(CFG_SLAB_NUMBER, 16'hFFFF);
		write_reg(CFG_BLOCK_COUNT, 16'd1024);
		send_cmd(CMD_ALLOC, 7'd64, '0, '0);
		send_cmd(CMD_FREE, '0, 16'hFFFF, 10'd64);
		send_cmd(CMD_FREE, '0, 16'hFFFF, 10'd1);
		send_cmd(CMD_FREE, '0, 16'h0000, 10'd1023);
		send_cmd(CMD_FREE, '0, 16'hFFFE, 10'd0);
		send_cmd(CMD_ALLOC, 7'd3, '0, '0);
		send_cmd(CMD_ALLOC, 7'd65, '0, '0);
		wait_drain();

		write_reg(CFG_SLAB_NUMBER, CFG_W'($urandom));
		write_reg(CFG_BLOCK_COUNT, 16'd1024);
		long_stall_req = 1'b1;
		random_phase(70);
		wait_drain();

		// small limit: the bump pointer stops at it; freed blocks come from the list first
		write_reg(CFG_SLAB_NUMBER, CFG_W'($urandom));
		write_reg(CFG_BLOCK_COUNT, CFG_W'($urandom_range(32, 200)));
		random_phase(70);
		wait_drain();

		write_reg(CFG_SLAB_NUMBER, CFG_W'($urandom));
		write_reg(CFG_BLOCK_COUNT, CFG_W'($urandom_range(1, 1024)));
		random_phase(70);
		wait_drain();

		// double free last: it leaves a loop in the list
		twice = BLK_W'($urandom_range(0, 1023));
		send_cmd(CMD_FREE, '0, slab_now, twice);
		send_cmd(CMD_FREE, '0, slab_now, twice);
		send_cmd(CMD_ALLOC, 7'd6, '0, '0);
		wait_drain();

		$display("Run covered %0d allocate and %0d free commands across %0d register writes,",
			n_alloc, n_free, n_writes);
		$display("with a long response hold-off; %0d results were checked.", checked);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/fla_pkg.sv
design/fla_if.sv
design/fla_ram.sv
design/free_list_block_allocator.sv
design/fla_checker.sv
tb/fla_grant_checker.sv
tb/free_list_block_allocator_tb.sv
